// ===== hdl/wall_texture_column_stepper_assert.svh =====
// Assertion helpers for the wall texture column stepper checker.
`ifndef WALL_TEXTURE_COLUMN_STEPPER_ASSERT_SVH
`define WALL_TEXTURE_COLUMN_STEPPER_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define WTCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define WTCS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// What must hold in the cycle after reset is sampled low.
`define WTCS_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) else $error(msg);

`endif

// ===== hdl/wtcs_pkg.sv =====
package wtcs_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int DIR_FRAC        = 14;
    localparam int MAX_TEX_SIZE    = 1024;
    localparam int MAX_SCREEN_ROWS = 2048;
    localparam int TEX_CFG_W       = 11;
    localparam int SCR_CFG_W       = 12;
    localparam int CFG_DATA_W      = 12;
    localparam int CFG_IDX_W       = 2;
    localparam int TEXC_W          = $clog2(MAX_TEX_SIZE);
    localparam int STEP_W          = TEX_CFG_W + FRAC_BITS;
    localparam int OFFS_W          = 18;
    localparam int POS_W           = OFFS_W + STEP_W + 1;
    localparam int DIV_CNT_W       = $clog2(STEP_W);
    localparam int CMD_DEPTH_DEF   = 2;
    localparam int OUT_DEPTH_DEF   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [11:0]        column;
        logic               side;
        logic [21:0]        player_x;
        logic [21:0]        player_y;
        logic signed [15:0] ray_dir_x;
        logic signed [15:0] ray_dir_y;
        logic [23:0]        wall_dist;
        logic [15:0]        wall_rows;
        logic [10:0]        row_first;
        logic [11:0]        row_stop;
    } t_item;

    typedef struct packed {
        logic [11:0] pixel_column;
        logic [10:0] pixel_row;
        logic [19:0] texel_index;
        logic        last;
    } t_result;

    // Clamped configuration as the datapath sees it.
    typedef struct packed {
        logic [TEX_CFG_W-1:0] tex_w;
        logic [TEX_CFG_W-1:0] tex_h;
        logic [SCR_CFG_W-2:0] half_screen;
    } t_cfg;

    typedef enum logic {
        CMD_LOAD,
        CMD_TICK
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                kind;
        logic [11:0]              column;
        logic [10:0]              start_row;
        logic [11:0]              end_row;
        logic [TEXC_W-1:0]        tex_col;
        logic [STEP_W-1:0]        step;
        logic signed [POS_W-1:0]  pos;
    } t_cmd;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_MUL,
        FS_COL,
        FS_DIV,
        FS_POS,
        FS_PUSH
    } t_front_state;

    function automatic logic [TEX_CFG_W-1:0] clamp_tex(input logic [TEX_CFG_W-1:0] v);
        logic [TEX_CFG_W-1:0] r;
        if (v == '0) begin
            r = TEX_CFG_W'(1);
        end else if (v > TEX_CFG_W'(MAX_TEX_SIZE)) begin
            r = TEX_CFG_W'(MAX_TEX_SIZE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hdl/wtcs_fifo.sv =====
module wtcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== hdl/wtcs_front.sv =====
module wtcs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wtcs_pkg::t_cfg  i_cfg,
    input  logic            i_push,
    input  wtcs_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_cmd_full,
    output logic            o_cmd_push,
    output wtcs_pkg::t_cmd  o_cmd
);
    import wtcs_pkg::*;

    t_front_state r_state;
    t_front_state n_state;

    logic [11:0]              r_column;
    logic [FRAC_BITS-1:0]     r_coord;
    logic [23:0]              r_dist;
    logic signed [15:0]       r_dir;
    logic                     r_mirror;
    logic [15:0]              r_lh;
    logic [10:0]              r_ds;
    logic [11:0]              r_de;
    logic signed [OFFS_W-1:0] r_offs;
    logic [FRAC_BITS-1:0]     r_prod;
    logic [TEXC_W-1:0]        r_tc;
    logic [STEP_W-1:0]        r_quo;
    logic [15:0]              r_rem;
    logic [DIV_CNT_W-1:0]     r_cnt;
    logic signed [POS_W-1:0]  r_pos;

    logic                           accept;
    logic                           start_acc;
    logic signed [40:0]             prod_full;
    logic [FRAC_BITS-1:0]           frac;
    logic [FRAC_BITS+TEX_CFG_W-1:0] col_prod;
    logic [16:0]                    trial;
    logic                           ge;
    logic [16:0]                    trial_sub;
    logic [TEX_CFG_W-1:0]           w_last;
    logic [TEX_CFG_W-1:0]           tc_mirror;

    assign accept    = i_push && !o_full;
    assign start_acc = accept && (i_item.mode == MODE_START);
    assign prod_full = $signed({1'b0, r_dist}) * r_dir;
    assign frac      = r_coord + r_prod;
    assign col_prod  = frac * i_cfg.tex_w;
    assign trial     = {r_rem, r_quo[STEP_W-1]};
    assign ge        = trial >= {1'b0, r_lh};
    assign trial_sub = trial - {1'b0, r_lh};
    assign w_last    = i_cfg.tex_w - TEX_CFG_W'(1);
    assign tc_mirror = w_last - {{(TEX_CFG_W-TEXC_W){1'b0}}, r_tc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: begin
                if (start_acc) begin
                    n_state = FS_MUL;
                end
            end
            FS_MUL: n_state = FS_COL;
            FS_COL: n_state = FS_DIV;
            FS_DIV: begin
                if (r_cnt == DIV_CNT_W'(STEP_W - 1)) begin
                    n_state = FS_POS;
                end
            end
            FS_POS: n_state = FS_PUSH;
            FS_PUSH: begin
                if (!i_cmd_full) begin
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        o_full         = (r_state != FS_IDLE) || i_cmd_full;
        o_cmd_push     = 1'b0;
        o_cmd.kind     = CMD_TICK;
        o_cmd.column   = r_column;
        o_cmd.start_row = r_ds;
        o_cmd.end_row  = r_de;
        o_cmd.tex_col  = r_mirror ? tc_mirror[TEXC_W-1:0] : r_tc;
        o_cmd.step     = r_quo;
        o_cmd.pos      = r_pos;
        unique case (r_state)
            FS_IDLE: o_cmd_push = accept && (i_item.mode == MODE_TICK);
            FS_PUSH: begin
                o_cmd_push = !i_cmd_full;
                o_cmd.kind = CMD_LOAD;
            end
            default: o_cmd_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            FS_IDLE: begin
                if (start_acc) begin
                    r_column <= i_item.column;
                    r_dist   <= i_item.wall_dist;
                    r_ds     <= i_item.row_first;
                    r_lh     <= (i_item.wall_rows == '0) ? 16'd1 : i_item.wall_rows;
                    r_de     <= (i_item.row_stop > 12'(MAX_SCREEN_ROWS)) ?
                                12'(MAX_SCREEN_ROWS) : i_item.row_stop;
                    if (i_item.side) begin
                        r_coord <= i_item.player_x[FRAC_BITS-1:0];
                        r_dir   <= i_item.ray_dir_x;
                    end else begin
                        r_coord <= i_item.player_y[FRAC_BITS-1:0];
                        r_dir   <= i_item.ray_dir_y;
                    end
                    r_mirror <= (!i_item.side && (i_item.ray_dir_x > 16'sd0)) ||
                                (i_item.side && (i_item.ray_dir_y < 16'sd0));
                end
            end
            FS_MUL: begin
                r_prod <= prod_full[DIR_FRAC+FRAC_BITS-1:DIR_FRAC];
                r_offs <= $signed({7'b0, r_ds}) - $signed({7'b0, i_cfg.half_screen})
                          + $signed({3'b0, r_lh[15:1]});
            end
            FS_COL: begin
                r_tc  <= col_prod[FRAC_BITS+TEXC_W-1:FRAC_BITS];
                r_quo <= {i_cfg.tex_h, {FRAC_BITS{1'b0}}};
                r_rem <= '0;
                r_cnt <= '0;
            end
            FS_DIV: begin
                r_rem <= ge ? trial_sub[15:0] : trial[15:0];
                r_quo <= {r_quo[STEP_W-2:0], ge};
                r_cnt <= r_cnt + DIV_CNT_W'(1);
            end
            FS_POS: begin
                r_pos <= r_offs * $signed({1'b0, r_quo});
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/wtcs_back.sv =====
module wtcs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wtcs_pkg::t_cfg    i_cfg,
    input  logic              i_cmd_empty,
    input  wtcs_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_out_full,
    output logic              o_out_push,
    output wtcs_pkg::t_result o_out
);
    import wtcs_pkg::*;

    localparam int PINT_W = POS_W - FRAC_BITS - 1;

    logic                    r_active;
    logic [11:0]             r_column;
    logic [10:0]             r_cur_row;
    logic [11:0]             r_end_row;
    logic [TEXC_W-1:0]       r_tc;
    logic [STEP_W-1:0]       r_step;
    logic signed [POS_W-1:0] r_pos;

    logic                    r_p1_valid;
    logic [11:0]             r_p1_column;
    logic [10:0]             r_p1_row;
    logic [TEXC_W-1:0]       r_p1_trow;
    logic [TEXC_W-1:0]       r_p1_tc;
    logic                    r_p1_last;

    logic                 p1_ready;
    logic                 load;
    logic                 emit;
    logic                 last;
    logic [PINT_W-1:0]    pos_int;
    logic [TEX_CFG_W-1:0] h_max;
    logic [TEXC_W-1:0]    trow;
    logic [20:0]          texel_full;

    assign p1_ready   = !r_p1_valid || !i_out_full;
    assign o_cmd_pop  = !i_cmd_empty && p1_ready;
    assign load       = o_cmd_pop && (i_cmd.kind == CMD_LOAD);
    assign emit       = o_cmd_pop && (i_cmd.kind == CMD_TICK) && r_active;
    assign last       = ({1'b0, r_cur_row} + 12'd1) >= r_end_row;
    assign pos_int    = r_pos[POS_W-2:FRAC_BITS];
    assign h_max      = i_cfg.tex_h - TEX_CFG_W'(1);
    assign o_out_push = r_p1_valid && !i_out_full;
    assign texel_full = i_cfg.tex_w * r_p1_trow + r_p1_tc;

    always_comb begin
        priority if (r_pos[POS_W-1] || (r_pos == '0)) begin
            trow = '0;
        end else if (pos_int > PINT_W'(h_max)) begin
            trow = h_max[TEXC_W-1:0];
        end else begin
            trow = pos_int[TEXC_W-1:0];
        end
    end

    always_comb begin
        o_out.pixel_column = r_p1_column;
        o_out.pixel_row    = r_p1_row;
        o_out.texel_index  = texel_full[19:0];
        o_out.last         = r_p1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_p1_valid <= 1'b0;
        end else begin
            if (load) begin
                r_active <= {1'b0, i_cmd.start_row} < i_cmd.end_row;
            end else if (emit && last) begin
                r_active <= 1'b0;
            end
            if (emit) begin
                r_p1_valid <= 1'b1;
            end else if (o_out_push) begin
                r_p1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_column  <= i_cmd.column;
            r_cur_row <= i_cmd.start_row;
            r_end_row <= i_cmd.end_row;
            r_tc      <= i_cmd.tex_col;
            r_step    <= i_cmd.step;
            r_pos     <= i_cmd.pos;
        end else if (emit) begin
            r_pos     <= r_pos + $signed({{(POS_W-STEP_W){1'b0}}, r_step});
            r_cur_row <= r_cur_row + 11'd1;
        end
        if (emit) begin
            r_p1_column <= r_column;
            r_p1_row    <= r_cur_row;
            r_p1_trow   <= trow;
            r_p1_tc     <= r_tc;
            r_p1_last   <= last;
        end
    end

endmodule

// ===== hdl/wall_texture_column_stepper.sv =====
// Channel   Direction  Handshake                    Payload
// item      in         push / full                  i_item   (t_item)
// result    out        empty / pop                  o_result (t_result)
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A start request keeps the front busy through the take, the hit product, the
// texture column, 27 row step divider steps, the position product and hand-off
// to the command queue. A tick passes the front as it is taken; its pixel reaches
// the result ports, one pixel per cycle unless the result side stalls. Reset is
// synchronous and clears only control state. A stalled result side fills the
// result queue, the pixel stage and the command queue, then raises full.
module wall_texture_column_stepper #(
    parameter int CMD_DEPTH = wtcs_pkg::CMD_DEPTH_DEF,
    parameter int OUT_DEPTH = wtcs_pkg::OUT_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    input  wtcs_pkg::t_item                      i_item,
    output logic                                 full,
    output logic                                 empty,
    input  logic                                 pop,
    output wtcs_pkg::t_result                    o_result,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [wtcs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wtcs_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import wtcs_pkg::*;

    // Raw configuration registers, stored at their own widths.
    logic [TEX_CFG_W-1:0] r_tex_width;
    logic [TEX_CFG_W-1:0] r_tex_height;
    logic [SCR_CFG_W-1:0] r_screen_height;

    t_cfg    cfg;
    logic    cmd_full;
    logic    cmd_empty;
    logic    cmd_push;
    logic    cmd_pop;
    t_cmd    cmd_wr;
    t_cmd    cmd_rd;
    logic    out_full;
    logic    out_push;
    t_result out_wr;

    // The port is always free to take a write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width     <= TEX_CFG_W'(64);
            r_tex_height    <= TEX_CFG_W'(64);
            r_screen_height <= SCR_CFG_W'(480);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TEX_WIDTH:     r_tex_width     <= i_cfg_data[TEX_CFG_W-1:0];
                CFG_TEX_HEIGHT:    r_tex_height    <= i_cfg_data[TEX_CFG_W-1:0];
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[SCR_CFG_W-1:0];
                default: begin
                    // Drop writes to unmapped indexes.
                end
            endcase
        end
    end

    // Saturate the texture size to the supported range before use.
    always_comb begin
        cfg.tex_w       = clamp_tex(r_tex_width);
        cfg.tex_h       = clamp_tex(r_tex_height);
        cfg.half_screen = r_screen_height[SCR_CFG_W-1:1];
    end

    // Front: take requests, run the per-column setup, queue commands.
    wtcs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_wr)
    );

    // Command queue: lets the front finish a setup while the back stalls.
    wtcs_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_wr),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_rd),
        .o_empty (cmd_empty)
    );

    // Back: hold the column run and emit one pixel per tick while the run is active.
    wtcs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_rd),
        .o_cmd_pop   (cmd_pop),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_out       (out_wr)
    );

    // Result queue: the oldest pixel waits here until popped.
    wtcs_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_wr),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

// ===== hdl/wtcs_checker.sv =====
`include "wall_texture_column_stepper_assert.svh"

module wtcs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input wtcs_pkg::t_item   i_item,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input wtcs_pkg::t_result o_result
);
    import wtcs_pkg::*;

    logic start_take;
    logic row_ok;

    assign start_take = push && !full && (i_item.mode == MODE_START);
    assign row_ok     = (o_result.pixel_row < 11'd2047) || o_result.last;

    `WTCS_ASSERT_RST(a_reset_clear, empty && !full, "queues not clear after reset")
    `WTCS_ASSERT_NXT(a_result_held, !empty && !pop, !empty && $stable(o_result), "result moved")
    `WTCS_ASSERT_NXT(a_start_busy, start_take, full, "front not busy after a start")
    `WTCS_ASSERT_IMP(a_last_row, !empty, row_ok, "row past the screen without last")

endmodule

bind wall_texture_column_stepper wtcs_checker u_wtcs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .i_item   (i_item),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
